/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the audio frame delay line.
// Each macro clocks on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold in the same cycle as the trigger.
`define AFDL_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define AFDL_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* rtl/afdl_pkg.sv */
// Package for the audio frame delay line: item types, widths, register codes
// and the helpers that turn an item into channel lanes and back. No dependencies.
package afdl_pkg;

    localparam int SAMPLE_W        = 24;
    localparam int NUM_LANES       = 8;
    localparam int DELAY_W         = 21;
    localparam int DROP_W          = 20;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam int DEF_MAX_DELAY   = 4096;
    localparam int DEF_CHANNELS    = 8;
    localparam int DEF_SAMPLE_BITS = 24;

    // Register index codes (word index taken from paddr[2]).
    localparam logic REG_DELAY_FRAMES = 1'b0;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_ch0;
        logic signed [SAMPLE_W-1:0] sample_ch1;
        logic signed [SAMPLE_W-1:0] sample_ch2;
        logic signed [SAMPLE_W-1:0] sample_ch3;
        logic signed [SAMPLE_W-1:0] sample_ch4;
        logic signed [SAMPLE_W-1:0] sample_ch5;
        logic signed [SAMPLE_W-1:0] sample_ch6;
        logic signed [SAMPLE_W-1:0] sample_ch7;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_ch0;
        logic signed [SAMPLE_W-1:0] out_ch1;
        logic signed [SAMPLE_W-1:0] out_ch2;
        logic signed [SAMPLE_W-1:0] out_ch3;
        logic signed [SAMPLE_W-1:0] out_ch4;
        logic signed [SAMPLE_W-1:0] out_ch5;
        logic signed [SAMPLE_W-1:0] out_ch6;
        logic signed [SAMPLE_W-1:0] out_ch7;
    } t_out_item;

    typedef logic [NUM_LANES-1:0][SAMPLE_W-1:0] t_lanes;

    function automatic t_lanes in_to_lanes(input t_in_item item);
        t_lanes lanes;
        lanes[0] = item.sample_ch0;
        lanes[1] = item.sample_ch1;
        lanes[2] = item.sample_ch2;
        lanes[3] = item.sample_ch3;
        lanes[4] = item.sample_ch4;
        lanes[5] = item.sample_ch5;
        lanes[6] = item.sample_ch6;
        lanes[7] = item.sample_ch7;
        return lanes;
    endfunction

    function automatic t_out_item lanes_to_out(input t_lanes lanes);
        t_out_item item;
        item.out_ch0 = lanes[0];
        item.out_ch1 = lanes[1];
        item.out_ch2 = lanes[2];
        item.out_ch3 = lanes[3];
        item.out_ch4 = lanes[4];
        item.out_ch5 = lanes[5];
        item.out_ch6 = lanes[6];
        item.out_ch7 = lanes[7];
        return item;
    endfunction

endpackage

/* rtl/audio_frame_delay_line_unit.sv */
// Top level of the audio frame delay line: frame store, pointer, drop counter,
// APB register and the two-stage item pipeline. Depends on afdl_pkg and assert_macros.svh.
//
//   Channel  | Direction | Handshake            | Payload
//   ---------+-----------+----------------------+---------------------------
//   in       | input     | i_in_valid/o_in_stall | i_in_data   (t_in_item)
//   out      | output    | o_out_valid/i_out_stall| o_out_data (t_out_item)
//   config   | input     | psel/penable/pready  | paddr, pwdata, prdata
//
// One item is accepted per cycle when the output side keeps up. The edge that
// accepts an item also loads the first stage and the registered read of the frame
// store; the output register is loaded from the first stage at a later edge, once
// the output register is empty or being read, and the result can then be taken.
// Reset is synchronous and active low and needs no clearing pass over the store.
// A stall on the output backs up through the two stages and raises o_in_stall
// only once both are full.

`include "assert_macros.svh"

module audio_frame_delay_line_unit #(
    parameter int MAX_DELAY   = afdl_pkg::DEF_MAX_DELAY,
    parameter int CHANNELS    = afdl_pkg::DEF_CHANNELS,
    parameter int SAMPLE_BITS = afdl_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  afdl_pkg::t_in_item                  i_in_data,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output afdl_pkg::t_out_item                 o_out_data,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [afdl_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [afdl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [afdl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    import afdl_pkg::*;

    // Only the low SAMPLE_BITS of each sample survive, and never more than the
    // field width. Stored lanes are that wide and are zero-extended on the way out.
    localparam int KEEP_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int MEM_W     = CHANNELS * KEEP_BITS;
    localparam int PTR_W     = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int DLY_W     = $clog2(MAX_DELAY + 1);
    localparam logic [DLY_W-1:0]  MAX_DLY  = DLY_W'(MAX_DELAY);
    localparam logic [DROP_W-1:0] DROP_TOP = {DROP_W{1'b1}};
    localparam logic [DELAY_W-1:0] DELAY_MIN = {1'b1, {(DELAY_W-1){1'b0}}};

    // Configuration and control state.
    logic [DELAY_W-1:0] r_delay;
    logic [DLY_W-1:0]   r_pos_delay;   // effective positive delay, zero when none
    logic [DROP_W-1:0]  r_drop;        // frames still to drop
    logic [PTR_W-1:0]   r_ptr;         // next slot of the circular store
    logic               r_filled;      // the store has wrapped once since restart

    // Frame store and its registered read port.
    logic [MEM_W-1:0]   r_mem [MAX_DELAY];
    logic [MEM_W-1:0]   r_rd_data;

    // First stage: holds an item between acceptance and the output register.
    logic               r_s1_valid;
    logic               r_s1_mem;      // result comes from the store
    logic               r_s1_zero;     // store slot never written: result is silence
    logic [MEM_W-1:0]   r_s1_frame;

    // Output register.
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic               w_cfg_wr;
    logic               w_pos_en;
    logic               w_out_free;
    logic               w_s1_free;
    logic               w_s1_move;
    logic               w_in_acc;
    logic               w_mem_en;
    logic               w_wrap;
    logic [DLY_W-1:0]   w_ptr_inc;
    logic [MEM_W-1:0]   w_in_pack;
    logic [MEM_W-1:0]   w_sel;
    t_lanes             w_in_lanes;
    t_lanes             w_out_lanes;

    logic [DELAY_W-1:0] w_wdata;
    logic [DELAY_W-1:0] w_neg;
    logic [DLY_W-1:0]   n_pos_delay;
    logic [DROP_W-1:0]  n_drop;

    // ------------------------------------------------------------------
    // Register port. A write to the delay register restarts the block:
    // the pointer returns to zero, the store reads as silence again and
    // the drop counter is reloaded.
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign prdata   = {{(APB_DATA_W-DELAY_W){r_delay[DELAY_W-1]}}, r_delay};
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DELAY_FRAMES);

    assign w_wdata = pwdata[DELAY_W-1:0];
    assign w_neg   = ~w_wdata + DELAY_W'(1);

    always_comb begin
        n_pos_delay = '0;
        n_drop      = '0;
        if (w_wdata[DELAY_W-1]) begin
            // Negative delay: drop that many frames. The most negative value
            // saturates to the largest count the drop counter holds.
            if (w_wdata == DELAY_MIN) begin
                n_drop = DROP_TOP;
            end else begin
                n_drop = w_neg[DROP_W-1:0];
            end
        end else if (w_wdata != '0) begin
            // Positive delay, saturated to the depth of the store.
            if (w_wdata[DROP_W-1:0] > DROP_W'(MAX_DELAY)) begin
                n_pos_delay = MAX_DLY;
            end else begin
                n_pos_delay = DLY_W'(w_wdata[DROP_W-1:0]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The first stage moves on whenever the output register is
    // empty or being read; a new item enters whenever the first stage is
    // empty or moving.
    // ------------------------------------------------------------------
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign w_s1_free  = !r_s1_valid || w_out_free;
    assign w_in_acc   = i_in_valid && w_s1_free;
    assign o_in_stall = !w_s1_free;

    assign w_pos_en  = (r_pos_delay != '0);
    assign w_mem_en  = w_in_acc && w_pos_en;
    assign w_ptr_inc = DLY_W'(r_ptr) + DLY_W'(1);
    assign w_wrap    = (w_ptr_inc >= r_pos_delay);

    // Pack the used channels into a store word, each lane cut to KEEP_BITS.
    assign w_in_lanes = in_to_lanes(i_in_data);

    for (genvar c = 0; c < CHANNELS; c++) begin : g_pack
        assign w_in_pack[c*KEEP_BITS +: KEEP_BITS] = w_in_lanes[c][KEEP_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // Frame store: the old frame in the slot is read out and the new frame
    // written in at the same edge, so the read returns the earlier contents.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_mem_en) begin
            r_rd_data     <= r_mem[r_ptr];
            r_mem[r_ptr]  <= w_in_pack;
        end
    end

    // ------------------------------------------------------------------
    // Control state and first stage.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay     <= '0;
            r_pos_delay <= '0;
            r_drop      <= '0;
            r_ptr       <= '0;
            r_filled    <= 1'b0;
            r_s1_valid  <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_delay     <= w_wdata;
                r_pos_delay <= n_pos_delay;
                r_drop      <= n_drop;
                r_ptr       <= '0;
                r_filled    <= 1'b0;
            end else if (w_in_acc) begin
                if (w_pos_en) begin
                    r_ptr    <= w_wrap ? '0 : w_ptr_inc[PTR_W-1:0];
                    r_filled <= r_filled || w_wrap;
                end else if (r_drop != '0) begin
                    r_drop <= r_drop - DROP_W'(1);
                end
            end

            if (w_in_acc) begin
                // A dropped frame leaves the stage empty.
                r_s1_valid <= w_pos_en || (r_drop == '0);
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_mem   <= w_pos_en;
            r_s1_zero  <= !r_filled;
            r_s1_frame <= w_in_pack;
        end
    end

    // ------------------------------------------------------------------
    // Output register. Channels at or above CHANNELS read as zero.
    // ------------------------------------------------------------------
    always_comb begin
        if (r_s1_mem) begin
            w_sel = r_s1_zero ? '0 : r_rd_data;
        end else begin
            w_sel = r_s1_frame;
        end
    end

    for (genvar c = 0; c < NUM_LANES; c++) begin : g_unpack
        if (c < CHANNELS) begin : g_used
            assign w_out_lanes[c] = SAMPLE_W'(w_sel[c*KEEP_BITS +: KEEP_BITS]);
        end else begin : g_unused
            assign w_out_lanes[c] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_data <= lanes_to_out(w_out_lanes);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `AFDL_ASSERT_NEXT(a_cfg_restart, w_cfg_wr, (r_ptr == '0) && !r_filled, "restart did not clear pointer")
    `AFDL_ASSERT_SAME(a_ptr_range, w_pos_en, DLY_W'(r_ptr) < r_pos_delay, "pointer beyond delay")
    `AFDL_ASSERT_NEXT(a_drop_down, !w_cfg_wr, r_drop <= $past(r_drop), "drop count grew")
    `AFDL_ASSERT_NEXT(a_s1_hold, r_s1_valid && !w_s1_move, r_s1_valid, "stalled item lost")
    `AFDL_ASSERT_SAME(a_drop_exclusive, w_pos_en, r_drop == '0, "drop and delay both active")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the audio frame delay line: a predictor and a result
// scoreboard in one class, plus tasks that drive frames, stalls and the APB port.
// Depends on afdl_pkg and the audio_frame_delay_line_unit top level.
`timescale 1ns / 100ps

module tb_top;
    import afdl_pkg::*;

    // Timing and run-shape constants.
    localparam int DRAIN_CYCLES = 8;     // well past the two-stage pipeline
    localparam int QUIET_LIMIT  = 2000;  // cycles without any transfer before giving up
    localparam int PRINT_LIMIT  = 40;    // mismatch lines printed before going quiet
    localparam int RAND_PHASES  = 14;
    localparam int PHASE_FRAMES = 68;

    // Register map: the delay register at word 0, and a word with no register
    // behind it, used to check that such writes leave the block alone.
    localparam logic [APB_ADDR_W-1:0] DELAY_ADDR = {REG_DELAY_FRAMES, 2'b00};
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = 3'd4;

    localparam int unsigned DROP_LIMIT = (1 << DROP_W) - 1;

    // Channel view of a frame with channel 0 at index 0 (the first struct field
    // is the most significant slice, so an ascending range lines them up).
    typedef logic [0:NUM_LANES-1][SAMPLE_W-1:0] frame_words_t;

    // Predicts the delayed stream and holds the frames still owed by the block.
    class delay_line_scoreboard;
        t_in_item           history [DEF_MAX_DELAY];
        t_out_item          expected_frames [$];
        logic [DELAY_W-1:0] delay_reg;
        int unsigned        span;
        int unsigned        slot;
        int unsigned        drops_left;
        int unsigned        mismatches;
        int unsigned        frames_in;
        int unsigned        frames_checked;

        function new();
            delay_reg      = '0;
            mismatches     = 0;
            frames_in      = 0;
            frames_checked = 0;
            restart();
        endfunction

        // Any load of the delay register starts over as from reset: silent
        // history, pointer at zero, drop count reloaded from the new delay.
        function void restart();
            int d;
            d = $signed(delay_reg);
            foreach (history[i]) history[i] = '0;
            span       = 0;
            slot       = 0;
            drops_left = 0;
            if (d > 0) begin
                span = (d > DEF_MAX_DELAY) ? DEF_MAX_DELAY : d;
            end else if (d < 0) begin
                drops_left = (-d > DROP_LIMIT) ? DROP_LIMIT : -d;
            end
        endfunction

        function void write_reg(int index, logic [APB_DATA_W-1:0] value);
            if (index != REG_DELAY_FRAMES) return;
            delay_reg = value[DELAY_W-1:0];
            restart();
        endfunction

        function void note_frame(t_in_item frame);
            t_in_item    emitted;
            int unsigned p;
            frames_in++;
            emitted = frame;
            if (span > 0) begin
                p          = (slot >= span) ? 0 : slot;
                emitted    = history[p];
                history[p] = frame;
                p++;
                slot = (p >= span) ? 0 : p;
            end else if (drops_left > 0) begin
                drops_left--;
                return;
            end
            // Input and output items share one layout, so the bits carry over.
            expected_frames.push_back(t_out_item'(emitted));
        endfunction

        function int outstanding();
            return expected_frames.size();
        endfunction

        task note_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_LIMIT) $display("MISMATCH: %s", msg);
        endtask

        task check_result(t_out_item got);
            frame_words_t g;
            frame_words_t e;
            if (expected_frames.size() == 0) begin
                note_mismatch($sformatf("result %h arrived with nothing expected", got));
                return;
            end
            e = frame_words_t'(expected_frames.pop_front());
            g = frame_words_t'(got);
            frames_checked++;
            for (int c = 0; c < NUM_LANES; c++) begin
                if (g[c] !== e[c]) begin
                    note_mismatch($sformatf("result %0d out_ch%0d: got %h, expected %h",
                                            frames_checked, c, g[c], e[c]));
                end
            end
        endtask
    endclass

    // Clock, reset and the block's ports.
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  o_in_stall;
    t_in_item              in_data;
    logic                  o_out_valid;
    logic                  out_stall;
    t_out_item             o_out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Idle rates in percent of cycles, changed between phases.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    int unsigned quiet_cycles;
    int unsigned settings_loaded;

    delay_line_scoreboard sb;

    audio_frame_delay_line_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver decides at each falling edge whether to hold off the next
    // rising edge. With the rate at zero it takes every result.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Both channels are observed at the rising edge. o_in_stall mixes registers with
    // out_stall, set at the falling edge, and all else is registered, so what is read
    // here is what the edge acts on. Input goes first so even a direct path is predicted.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !o_in_stall) sb.note_frame(in_data);
            if (o_out_valid && !out_stall) sb.check_result(o_out_data);
        end
    end

    // Watchdog: any frame, result or register access counts as progress.
    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (psel && penable && pready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // One APB transfer: a setup phase, then the access phase held until pready.
    // A write is mirrored into the predictor, which is safe since the block is
    // idle whenever a register is touched. A further falling edge is then awaited so
    // that the next transfer never raises psel in the step that lowers it.
    task automatic apb_transfer(input logic write_en, input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        if (write_en) sb.write_reg(int'(addr) / 4, wdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // The register must read back as last written; only the register's own
    // bits are compared, whatever the block puts above them.
    task automatic check_delay_readback();
        logic [APB_DATA_W-1:0] rd;
        apb_transfer(1'b0, DELAY_ADDR, '0, rd);
        if (rd[DELAY_W-1:0] !== sb.delay_reg) begin
            sb.note_mismatch($sformatf("delay register reads %h, expected %h",
                                       rd[DELAY_W-1:0], sb.delay_reg));
        end
    endtask

    // Loads a new delay with random bits above the register's width, which the
    // block has to drop.
    task automatic load_delay(input int frames);
        logic [APB_DATA_W-1:0] noise;
        logic [APB_DATA_W-1:0] rd;
        noise = $urandom();
        apb_transfer(1'b1, DELAY_ADDR, {noise[APB_DATA_W-1:DELAY_W], DELAY_W'(frames)}, rd);
        settings_loaded++;
        check_delay_readback();
    endtask

    // Offers one frame, with random idle cycles ahead of it, and returns at the
    // falling edge after it is taken. Valid stays high into the next frame
    // unless that one starts with an idle cycle.
    task automatic send_frame(input t_in_item frame);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= frame;
        do @(posedge clk); while (o_in_stall);
        @(negedge clk);
    endtask

    // Stops offering frames and waits until every owed result has come out.
    // Dropped frames leave nothing to wait for, so a further drain wait then lets the
    // pipeline empty before a register may be written.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Random frame in which each channel is sometimes pinned to an extreme.
    function automatic t_in_item rand_frame();
        frame_words_t w;
        for (int c = 0; c < NUM_LANES; c++) begin
            case ($urandom_range(0, 7))
                0:       w[c] = 24'h7FFFFF;
                1:       w[c] = 24'h800000;
                2:       w[c] = 24'h000000;
                3:       w[c] = 24'hFFFFFF;
                default: w[c] = SAMPLE_W'($urandom());
            endcase
        end
        return t_in_item'(w);
    endfunction

    // Short delays in three picks of ten, so that the store wraps many times within a
    // phase, with medium delays, zero, drops, delays near the store size and saturating ones.
    function automatic int pick_delay();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(2, 12);
            3:       return $urandom_range(13, 700);
            4:       return 0;
            5, 6:    return -int'($urandom_range(1, 40));
            7:       return -int'($urandom_range(41, 3000));
            8:       return $urandom_range(4000, 4200);
            default: return $urandom_range(4097, 1048575);
        endcase
    endfunction

    initial begin
        logic [APB_DATA_W-1:0] rd;
        int                    delay;

        sb              = new();
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_data         = '0;
        out_stall       = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        quiet_cycles    = 0;
        settings_loaded = 0;
        send_idle_pct   = 36;
        recv_stall_pct  = 60;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Out of reset the delay is zero: extremes of the samples pass straight through.
        send_frame(t_in_item'({8{24'h7FFFFF}}));
        send_frame(t_in_item'({8{24'h800000}}));
        send_frame(t_in_item'('0));
        send_frame(t_in_item'({4{24'h555555, 24'hAAAAAA}}));
        drain();

        // A short positive delay: three silent frames, then the stream comes back.
        load_delay(3);
        repeat (6) send_frame(rand_frame());
        drain();

        // A negative delay drops the first two frames and passes the rest.
        load_delay(-2);
        repeat (4) send_frame(rand_frame());
        drain();

        // A write to a word with no register behind it changes nothing.
        apb_transfer(1'b1, SPARE_ADDR, $urandom(), rd);
        check_delay_readback();
        repeat (2) send_frame(rand_frame());
        drain();

        // Largest positive register value saturates to the store size, so the
        // output is silence cleared from whatever the store held before.
        load_delay(1048575);
        repeat (3) send_frame(rand_frame());
        drain();

        // Most negative register value: the longest possible run of drops.
        load_delay(-1048576);
        repeat (3) send_frame(rand_frame());
        drain();

        // Random phases, each loading a new delay. The first phases pin the
        // smallest delay, the full store, a written zero and the shortest drop.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph < RAND_PHASES / 3) begin
                send_idle_pct  = 36;
                recv_stall_pct = 60;
            end else if (ph < 2 * RAND_PHASES / 3) begin
                send_idle_pct  = 60;
                recv_stall_pct = 36;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            case (ph)
                0:       delay = 1;
                1:       delay = DEF_MAX_DELAY;
                2:       delay = 0;
                3:       delay = -1;
                default: delay = pick_delay();
            endcase
            load_delay(delay);
            repeat (PHASE_FRAMES) send_frame(rand_frame());
            drain();
        end

        if (sb.outstanding() != 0) begin
            sb.note_mismatch($sformatf("%0d results never arrived", sb.outstanding()));
        end
        $display("summary: %0d frames sent, %0d results checked, %0d delay settings loaded",
                 sb.frames_in, sb.frames_checked, settings_loaded);
        $display("summary: %0d mismatches found", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/afdl_pkg.sv
rtl/audio_frame_delay_line_unit.sv
tb/tb_top.sv
